FILE: src/ntc_pkg.sv
// Shared types and constants for the nearest-template L1 classifier.
// No dependencies; the design files refer to this package by scoped names, the bench imports it.
`default_nettype none

package ntc_pkg;

  localparam int CLASSES              = 10;
  localparam int FEATURES             = 13;
  localparam int UNIT_WEIGHT_FEATURES = 9;
  localparam int FEATURE_BITS         = 16;
  localparam int HEAVY_WEIGHT         = 9;

  localparam int CLS_W      = $clog2(CLASSES);
  localparam int TMPL_DEPTH = CLASSES * FEATURES;
  localparam int TMPL_AW    = $clog2(TMPL_DEPTH);

  localparam int DIST_W  = 22;
  localparam int DIFF_W  = FEATURE_BITS + 1;
  localparam int WDIFF_W = DIFF_W + 4;
  localparam int SUM_W   = DIST_W + 1;

  localparam logic [DIST_W-1:0] DIST_MAX     = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] LIMIT_RESET  = {DIST_W{1'b1}};

  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_TEST  = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [3:0]               template_class;
    logic [3:0]               feature_index;
    logic signed [15:0]       feature_value;
  } item_t;

  typedef struct packed {
    logic        matched;
    logic [3:0]  best_class;
    logic [21:0] best_distance;
  } result_t;

  // Control carried alongside each class slot through the accumulate pipeline
  typedef struct packed {
    logic             valid;
    logic [CLS_W-1:0] cls;
    logic             last;
    logic             heavy;
  } stage_ctl_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_DRAIN
  } seq_state_t;

endpackage

`default_nettype wire

FILE: src/ntc_template_ram.sv
// Template store: CLASSES*FEATURES feature values, one write and one read port.
// Synchronous (registered) read. Depends on ntc_pkg.
`default_nettype none

module ntc_template_ram (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [ntc_pkg::TMPL_AW-1:0]          wr_addr,
  input  wire logic signed [ntc_pkg::FEATURE_BITS-1:0] wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [ntc_pkg::TMPL_AW-1:0]          rd_addr,
  output logic signed [ntc_pkg::FEATURE_BITS-1:0]   rd_data
);

  logic signed [ntc_pkg::FEATURE_BITS-1:0] mem [ntc_pkg::TMPL_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/ntc_dist_ram.sv
// Per-class running distance store with one valid bit per class.
// An entry that is not valid reads as zero; clear_all drops every entry. Depends on ntc_pkg.
`default_nettype none

module ntc_dist_ram (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             clear_all,
  input  wire logic                             wr_en,
  input  wire logic [ntc_pkg::CLS_W-1:0]        wr_cls,
  input  wire logic [ntc_pkg::DIST_W-1:0]       wr_data,
  input  wire logic                             rd_en,
  input  wire logic [ntc_pkg::CLS_W-1:0]        rd_cls,
  output logic [ntc_pkg::DIST_W-1:0]            rd_data
);

  logic [ntc_pkg::DIST_W-1:0]  mem [ntc_pkg::CLASSES];
  logic [ntc_pkg::CLASSES-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_cls] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_cls] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= valid[rd_cls] ? mem[rd_cls] : '0;
    end
  end

endmodule

`default_nettype wire

FILE: src/ntc_accum.sv
// Accumulate pipeline: weighted |test - template|, saturating add, write-back
// and running minimum over classes; emits the result at the end of a vector. Depends on ntc_pkg.
`default_nettype none

module ntc_accum (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire ntc_pkg::stage_ctl_t                  issue_ctl,
  input  wire logic signed [ntc_pkg::FEATURE_BITS-1:0] test_value,
  input  wire logic signed [ntc_pkg::FEATURE_BITS-1:0] tmpl_value,
  input  wire logic [ntc_pkg::DIST_W-1:0]           dist_value,
  input  wire logic [ntc_pkg::DIST_W-1:0]           reject_limit,
  output logic                                      dist_wr_en,
  output logic [ntc_pkg::CLS_W-1:0]                 dist_wr_cls,
  output logic [ntc_pkg::DIST_W-1:0]                dist_wr_data,
  output logic                                      dist_clear,
  output logic                                      done,
  output logic                                      result_valid,
  output ntc_pkg::result_t                          result
);

  ntc_pkg::stage_ctl_t p1, p2, p3;

  logic signed [ntc_pkg::DIFF_W-1:0] diff;
  logic [ntc_pkg::DIFF_W-1:0]        mag;
  logic [ntc_pkg::WDIFF_W-1:0]       wdiff;
  logic [ntc_pkg::WDIFF_W-1:0]       wd2;
  logic [ntc_pkg::DIST_W-1:0]        dist2;
  logic [ntc_pkg::SUM_W-1:0]         sum;
  logic [ntc_pkg::DIST_W-1:0]        sat;
  logic [ntc_pkg::DIST_W-1:0]        sum3;
  logic [ntc_pkg::DIST_W-1:0]        best_dist;
  logic [ntc_pkg::CLS_W-1:0]         best_cls;
  logic                              better;
  logic [ntc_pkg::DIST_W-1:0]        best_dist_next;
  logic [ntc_pkg::CLS_W-1:0]         best_cls_next;
  logic                              final_cls;
  logic                              emit;
  logic                              hit;

  // stage 1: memory data is in, form the weighted absolute difference
  always_comb begin
    diff  = ntc_pkg::DIFF_W'(test_value) - ntc_pkg::DIFF_W'(tmpl_value);
    mag   = diff[ntc_pkg::DIFF_W-1] ? ntc_pkg::DIFF_W'(-diff) : ntc_pkg::DIFF_W'(diff);
    // weight 9 as x*8 + x
    wdiff = p1.heavy ? (ntc_pkg::WDIFF_W'({mag, 3'b000}) + ntc_pkg::WDIFF_W'(mag))
                     : ntc_pkg::WDIFF_W'(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= '0;
      p2 <= '0;
      p3 <= '0;
    end else begin
      p1 <= issue_ctl;
      p2 <= p1;
      p3 <= p2;
    end
  end

  always_ff @(posedge clk) begin
    wd2   <= wdiff;
    dist2 <= dist_value;
  end

  // stage 2: saturating add and write-back
  always_comb begin
    sum = ntc_pkg::SUM_W'(dist2) + ntc_pkg::SUM_W'(wd2);
    sat = sum[ntc_pkg::SUM_W-1] ? ntc_pkg::DIST_MAX : sum[ntc_pkg::DIST_W-1:0];
  end

  // the closing feature does not need its sums stored: the store is cleared anyway
  assign dist_wr_en   = p2.valid && !p2.last;
  assign dist_wr_cls  = p2.cls;
  assign dist_wr_data = sat;

  always_ff @(posedge clk) begin
    sum3 <= sat;
  end

  // stage 3: running minimum, strict less so the lowest class keeps ties
  always_comb begin
    better         = (p3.cls == '0) || (sum3 < best_dist);
    best_dist_next = better ? sum3 : best_dist;
    best_cls_next  = better ? p3.cls : best_cls;
    final_cls      = p3.valid && (p3.cls == ntc_pkg::CLS_W'(ntc_pkg::CLASSES - 1));
    emit           = final_cls && p3.last;
    hit            = best_dist_next < reject_limit;
  end

  assign done       = final_cls;
  assign dist_clear = emit;

  always_ff @(posedge clk) begin
    if (p3.valid) begin
      best_dist <= best_dist_next;
      best_cls  <= best_cls_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.matched       <= hit;
      result.best_class    <= hit ? 4'(best_cls_next) : 4'd0;
      result.best_distance <= best_dist_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/nearest_template_l1_classifier_unit.sv
// Top level of the nearest-template L1 classifier: command sequencer, reject limit
// register, template store, distance store and accumulate pipeline. Depends on ntc_pkg.
//
// Usage:
//   Input: an item beat is taken at a clock edge with start high and busy low.
//   A store beat (action 0) writes one template feature in that cycle; busy stays
//   low, so stores can follow one per cycle. A test beat (action 1) with an index
//   inside the vector raises busy for the whole pass over the classes: the sequencer
//   reads one template entry and one running distance per class per cycle, then a
//   three-stage pipeline weights, adds, writes back and tracks the minimum.
//   A test item therefore holds off the next beat until busy falls again.
//   A test beat outside the vector, or a store out of range, is dropped.
//   Output: for a test beat carrying the last feature index, result_valid is high
//   for one cycle once the pass is through, with result. The receiver
//   cannot stall; nothing is held back for it.
//   Config: cfg_valid/cfg_ready write the reject limit; cfg_ready is always high.
//   Write it only while the block is idle.
//   Reset (rst, synchronous): running distances clear to zero, the reject limit
//   goes to its maximum, no result is pending. Templates must be written before use.
`default_nettype none

module nearest_template_l1_classifier_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire ntc_pkg::item_t              item,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ntc_pkg::DIST_W-1:0]  cfg_data,
  output logic                             result_valid,
  output ntc_pkg::result_t                 result
);

  ntc_pkg::seq_state_t state, state_next;

  logic [ntc_pkg::DIST_W-1:0]             reject_limit;
  logic [ntc_pkg::CLS_W-1:0]              cls_cnt;
  logic [ntc_pkg::TMPL_AW-1:0]            rd_addr;
  logic signed [ntc_pkg::FEATURE_BITS-1:0] val_q;
  logic                                   heavy_q;
  logic                                   last_q;

  logic                                   accept;
  logic                                   idx_ok;
  logic                                   store_go;
  logic                                   test_go;
  logic                                   issue;
  logic [ntc_pkg::TMPL_AW-1:0]            wr_addr;
  ntc_pkg::stage_ctl_t                    issue_ctl;

  logic signed [ntc_pkg::FEATURE_BITS-1:0] tmpl_rd;
  logic [ntc_pkg::DIST_W-1:0]             dist_rd;
  logic                                   dist_wr_en;
  logic [ntc_pkg::CLS_W-1:0]              dist_wr_cls;
  logic [ntc_pkg::DIST_W-1:0]             dist_wr_data;
  logic                                   dist_clear;
  logic                                   done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reject_limit <= ntc_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      reject_limit <= cfg_data;
    end
  end

  assign accept   = start && !busy;
  assign idx_ok   = int'(item.feature_index) < ntc_pkg::FEATURES;
  assign store_go = accept && (item.action == ntc_pkg::ACT_STORE) && idx_ok
                    && (int'(item.template_class) < ntc_pkg::CLASSES);
  assign test_go  = accept && (item.action == ntc_pkg::ACT_TEST) && idx_ok;
  assign wr_addr  = ntc_pkg::TMPL_AW'(int'(item.template_class) * ntc_pkg::FEATURES
                                      + int'(item.feature_index));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ntc_pkg::SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    issue      = 1'b0;
    unique case (state)
      ntc_pkg::SEQ_IDLE: begin
        busy = 1'b0;
        if (test_go) begin
          state_next = ntc_pkg::SEQ_RUN;
        end
      end
      ntc_pkg::SEQ_RUN: begin
        issue = 1'b1;
        if (cls_cnt == ntc_pkg::CLS_W'(ntc_pkg::CLASSES - 1)) begin
          state_next = ntc_pkg::SEQ_DRAIN;
        end
      end
      ntc_pkg::SEQ_DRAIN: begin
        if (done) begin
          state_next = ntc_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_next = ntc_pkg::SEQ_IDLE;
      end
    endcase
  end

  // one class per cycle; the template address steps by one vector length
  always_ff @(posedge clk) begin
    if (test_go) begin
      cls_cnt <= '0;
      rd_addr <= ntc_pkg::TMPL_AW'(item.feature_index);
      val_q   <= item.feature_value;
      heavy_q <= int'(item.feature_index) >= ntc_pkg::UNIT_WEIGHT_FEATURES;
      last_q  <= int'(item.feature_index) == ntc_pkg::FEATURES - 1;
    end else if (issue) begin
      cls_cnt <= cls_cnt + ntc_pkg::CLS_W'(1);
      rd_addr <= rd_addr + ntc_pkg::TMPL_AW'(ntc_pkg::FEATURES);
    end
  end

  always_comb begin
    issue_ctl.valid = issue;
    issue_ctl.cls   = cls_cnt;
    issue_ctl.last  = last_q;
    issue_ctl.heavy = heavy_q;
  end

  ntc_template_ram u_tmpl (
    .clk     (clk),
    .wr_en   (store_go),
    .wr_addr (wr_addr),
    .wr_data (item.feature_value),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (tmpl_rd)
  );

  ntc_dist_ram u_dist (
    .clk       (clk),
    .rst       (rst),
    .clear_all (dist_clear),
    .wr_en     (dist_wr_en),
    .wr_cls    (dist_wr_cls),
    .wr_data   (dist_wr_data),
    .rd_en     (issue),
    .rd_cls    (cls_cnt),
    .rd_data   (dist_rd)
  );

  ntc_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .issue_ctl    (issue_ctl),
    .test_value   (val_q),
    .tmpl_value   (tmpl_rd),
    .dist_value   (dist_rd),
    .reject_limit (reject_limit),
    .dist_wr_en   (dist_wr_en),
    .dist_wr_cls  (dist_wr_cls),
    .dist_wr_data (dist_wr_data),
    .dist_clear   (dist_clear),
    .done         (done),
    .result_valid (result_valid),
    .result       (result)
  );

  // a result only closes a test pass
  a_result_after_pass: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == ntc_pkg::SEQ_DRAIN)
    else $error("result without a finished test pass");

  // result strobes never come back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  // a match must be below the limit in force
  a_match_below_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.matched |-> result.best_distance < reject_limit)
    else $error("match reported at or above reject limit");

  // no distance write-back while idle
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == ntc_pkg::SEQ_IDLE |-> !dist_wr_en)
    else $error("distance write while sequencer idle");

endmodule

`default_nettype wire

FILE: bench/tb_nearest_template_l1_classifier_unit.sv
// Self-checking bench for nearest_template_l1_classifier_unit: queued item beats, a scoreboard
// predicted per accepted beat, and reject limit changes between drained phases.
// Depends on ntc_pkg and the unit's RTL only.
`default_nettype none

module tb_nearest_template_l1_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ntc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS = 80;
  localparam int FULL_RANGE = -1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t item = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [DIST_W-1:0] cfg_data = '0;
  logic result_valid;
  result_t result;

  nearest_template_l1_classifier_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  always #2 clk = ~clk;

  item_t feature_beats[$];
  result_t verdicts_due[$];

  // Predictor state
  logic signed [15:0] tmpl_mirror [CLASSES][FEATURES];
  logic [DIST_W-1:0] class_dist [CLASSES] = '{default: '0};
  logic [DIST_W-1:0] limit_mirror = LIMIT_RESET;

  // Generator-side view of the templates, used to aim test values near a class
  logic signed [15:0] planned_tmpl [CLASSES][FEATURES];
  int planned_items = 0;

  int unsigned mismatches = 0;
  int cycle_count = 0;
  logic item_taken = 1'b0;
  int burst_left = 8;
  int gap_left = 0;

  task automatic classify_beat(input item_t beat);
    longint gap;
    longint total;
    int best;
    logic [DIST_W-1:0] best_dist;
    result_t verdict;
    if (beat.feature_index >= FEATURES) return;
    if (beat.action == ACT_STORE) begin
      if (beat.template_class < CLASSES)
        tmpl_mirror[beat.template_class][beat.feature_index] = beat.feature_value;
      return;
    end
    for (int c = 0; c < CLASSES; c++) begin
      gap = longint'($signed(beat.feature_value))
          - longint'(tmpl_mirror[c][beat.feature_index]);
      if (gap < 0) gap = -gap;
      if (beat.feature_index >= UNIT_WEIGHT_FEATURES) gap = gap * HEAVY_WEIGHT;
      total = longint'(class_dist[c]) + gap;
      class_dist[c] = (total > longint'(DIST_MAX)) ? DIST_MAX : total[DIST_W-1:0];
    end
    if (beat.feature_index != FEATURES - 1) return;
    best = 0;
    best_dist = class_dist[0];
    for (int c = 1; c < CLASSES; c++) begin
      if (class_dist[c] < best_dist) begin
        best_dist = class_dist[c];
        best = c;
      end
    end
    verdict.matched = best_dist < limit_mirror;
    verdict.best_class = verdict.matched ? 4'(best) : 4'd0;
    verdict.best_distance = best_dist;
    verdicts_due.push_back(verdict);
    for (int c = 0; c < CLASSES; c++) class_dist[c] = '0;
  endtask

  // Scoreboard side: sample at the rising edge, before the unit's registers move
  always @(posedge clk) begin
    result_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= start && !busy;
      if (result_valid) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected result beat: matched %0d best_class %0d best_distance %0d",
                 result.matched, result.best_class, result.best_distance);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (result.matched !== want.matched) begin
            $error("matched: expected %0d, got %0d", want.matched, result.matched);
            mismatches++;
          end
          if (result.best_class !== want.best_class) begin
            $error("best_class: expected %0d, got %0d", want.best_class, result.best_class);
            mismatches++;
          end
          if (result.best_distance !== want.best_distance) begin
            $error("best_distance: expected %0d, got %0d",
                   want.best_distance, result.best_distance);
            mismatches++;
          end
        end
      end
      if (start && !busy) classify_beat(item);
    end
  end

  // Item driver: bursts of beats with random gaps, start held until the beat is taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (feature_beats.size() > 0) begin
        item <= feature_beats.pop_front();
        start <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic plan_store(input int cls, input int idx, input logic [15:0] value);
    item_t beat;
    beat.action = ACT_STORE;
    beat.template_class = 4'(cls);
    beat.feature_index = 4'(idx);
    beat.feature_value = value;
    if (cls < CLASSES && idx < FEATURES) planned_tmpl[cls][idx] = value;
    feature_beats.push_back(beat);
    planned_items++;
  endtask

  task automatic plan_test(input int idx, input logic [15:0] value);
    item_t beat;
    beat.action = ACT_TEST;
    beat.template_class = 4'($urandom_range(0, 15));
    beat.feature_index = 4'(idx);
    beat.feature_value = value;
    feature_beats.push_back(beat);
    planned_items++;
  endtask

  // One test vector aimed at class cls; spread FULL_RANGE means unrelated values.
  // A messy vector may skip or repeat indices and can carry stray stores and noise.
  task automatic plan_vector(input int cls, input int spread, input bit messy);
    int roll;
    int jitter;
    int copies;
    logic [15:0] value;
    for (int i = 0; i < FEATURES; i++) begin
      copies = 1;
      if (messy) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          plan_store($urandom_range(0, CLASSES - 1), $urandom_range(0, FEATURES - 1),
                     16'($urandom));
        end else if (roll < 6) begin
          plan_test($urandom_range(FEATURES, 15), 16'($urandom));
        end else if (roll < 8) begin
          plan_store($urandom_range(CLASSES, 15), $urandom_range(0, 15), 16'($urandom));
        end else if (roll < 9) begin
          plan_store($urandom_range(0, 15), $urandom_range(FEATURES, 15), 16'($urandom));
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) copies = 0;
        else if (roll < 6) copies = 2;
      end
      for (int n = 0; n < copies; n++) begin
        if (spread == FULL_RANGE) begin
          value = 16'($urandom);
        end else begin
          jitter = int'($urandom_range(0, 2 * spread)) - spread;
          value = planned_tmpl[cls][i] + 16'(jitter);
        end
        plan_test(i, value);
      end
    end
  endtask

  task automatic write_limit(input logic [DIST_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_mirror = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data <= DIST_W'($urandom);
  endtask

  // Sender pause: nothing queued, nothing in flight, then room for trailing busy cycles
  task automatic drain_wait();
    while (feature_beats.size() != 0 || start || verdicts_due.size() != 0 || busy)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int target;
    int spread;
    logic [DIST_W-1:0] limit_value;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Templates: class 0 at the floor, class 1 at the ceiling, class 5 a copy of class 3
    for (int c = 0; c < CLASSES; c++) begin
      for (int i = 0; i < FEATURES; i++) begin
        if (c == 0) plan_store(c, i, 16'h8000);
        else if (c == 1) plan_store(c, i, 16'h7fff);
        else if (c == 5) plan_store(c, i, planned_tmpl[3][i]);
        else plan_store(c, i, 16'($urandom));
      end
    end
    // Stores outside the store are dropped
    plan_store(10, 0, 16'h5555);
    plan_store(15, 15, 16'haaaa);
    plan_store(2, 13, 16'h1234);
    plan_store(12, 14, 16'hffff);
    // Test beats outside the vector add nothing
    plan_test(13, 16'h7fff);
    plan_test(15, 16'h8000);
    // Exact tie between classes 3 and 5, then exact hits on the extremes
    plan_vector(3, 0, 1'b0);
    plan_vector(1, 0, 1'b0);
    plan_vector(0, 0, 1'b0);
    // Every class distance saturates; the tie at the ceiling misses the reset limit
    for (int c = 0; c < CLASSES; c++) begin
      plan_store(c, 9, 16'h8000);
      plan_store(c, 12, 16'h8000);
    end
    repeat (8) plan_test(9, 16'h7fff);
    plan_test(12, 16'h7fff);
    drain_wait();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: limit_value = '0;
        1: limit_value = DIST_W'(1);
        2: limit_value = DIST_W'($urandom_range(1, 4000));
        3: limit_value = DIST_W'($urandom_range(4000, 400000));
        4: limit_value = DIST_MAX;
        default: limit_value = DIST_W'($urandom_range(400000, 4194302));
      endcase
      write_limit(limit_value);
      target = planned_items + PHASE_ITEMS;
      while (planned_items < target) begin
        case ($urandom_range(0, 4))
          0: spread = FULL_RANGE;
          1: spread = 0;
          2: spread = 8;
          3: spread = 64;
          default: spread = 2048;
        endcase
        plan_vector($urandom_range(0, CLASSES - 1), spread, $urandom_range(0, 3) != 0);
      end
      drain_wait();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
